@@ design/lfs_pkg.sv @@
// Shared types, codes and constants of the LED fade sequencer.
package lfs_pkg;

  // Fixed sizes and defaults.
  localparam int unsigned LFS_PWM_TOP    = 1000;
  localparam int unsigned LFS_NUM_CH     = 4;
  localparam int unsigned LFS_DUTY_W     = 15;
  localparam int unsigned LFS_ADDR_W     = 5;
  localparam int unsigned LFS_DATA_W     = 32;

  // Scale factors of the animation.
  localparam int unsigned LFS_TIME_SCALE = 10;
  localparam int unsigned LFS_PERCENT    = 100;
  localparam int unsigned LFS_MAN_STEPS  = 50;
  localparam int unsigned LFS_SPOT_TICKS = 20;

  // Reset values of the configuration registers.
  localparam int unsigned LFS_RST_REFRESH  = 1;
  localparam int unsigned LFS_RST_FADE_ON  = 1000;
  localparam int unsigned LFS_RST_STAY_ON  = 5000;
  localparam int unsigned LFS_RST_FADE_OFF = 1000;
  localparam int unsigned LFS_BRIGHT_DIV   = 5;
  localparam int unsigned LFS_SPOT_DIV     = 20;

  // Shared divider geometry: two quotient bits per cycle.
  localparam int unsigned LFS_DIVIDEND_W = 32;
  localparam int unsigned LFS_DIVISOR_W  = 16;
  localparam int unsigned LFS_DIV_RADIX_BITS = 2;
  localparam int unsigned LFS_DIV_STEPS  = LFS_DIVIDEND_W / LFS_DIV_RADIX_BITS;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_LIGHT  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_MANUAL = 3'd3,
    CMD_PING   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_REFRESH  = 3'd0,
    REG_FADE_ON  = 3'd1,
    REG_STAY_ON  = 3'd2,
    REG_FADE_OFF = 3'd3,
    REG_BRIGHT   = 3'd4,
    REG_SPOT     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LIGHT  = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_PING   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_OFF       = 3'd0,
    PH_FADE_ON   = 3'd1,
    PH_STAY      = 3'd2,
    PH_FADE_OFF  = 3'd3,
    PH_DONE      = 3'd4,
    PH_MAN_START = 3'd5,
    PH_MAN_FADE  = 3'd6,
    PH_MAN_STOP  = 3'd7
  } phase_t;

  // Ping mode reuses the fade-on code for its spot phase.
  localparam phase_t PH_SPOT = PH_FADE_ON;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MOD_START,
    SQ_MOD_WAIT,
    SQ_QUO_START,
    SQ_QUO_WAIT,
    SQ_APPLY
  } seq_t;

  // Input word.
  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  level_percent;
    logic [15:0] ping_timeout;
  } cmd_word_t;

  // Output word.
  typedef struct packed {
    logic [LFS_DUTY_W-1:0] duty_ch0;
    logic [LFS_DUTY_W-1:0] duty_ch1;
    logic [LFS_DUTY_W-1:0] duty_ch2;
    logic [LFS_DUTY_W-1:0] duty_ch3;
    logic                  running;
  } duty_word_t;

  // Divider control and result.
  typedef struct packed {
    logic                      start;
    logic [LFS_DIVIDEND_W-1:0] dividend;
    logic [LFS_DIVISOR_W-1:0]  divisor;
  } div_ctl_t;

  typedef struct packed {
    logic                      done;
    logic [LFS_DIVIDEND_W-1:0] quotient;
    logic [LFS_DIVISOR_W-1:0]  remainder;
  } div_res_t;

endpackage

@@ design/led_fade_sequencer.sv @@
// Top level of the LED fade sequencer: command channel, APB registers and animation sequencer.
// The block takes one command word at a time and returns exactly one word of four
// active-low duty values and a running flag for each. A tick in light, manual or
// ping mode makes two passes through the shared radix-4 divider before the result
// word is loaded (first the tick counter modulo the refresh interval, then the fade
// step or the ping rotation check). Start, stop and unknown commands, and ticks
// while idle, go to the update without the divider. The next command word is
// accepted from the cycle after the result word is loaded. A result word may wait
// on the output while the next command word is accepted, and the result of that
// word is then held back until the first is taken. The user must write registers over
// APB only while no command is in flight; the block itself does not enforce it.
module led_fade_sequencer import lfs_pkg::*; #(
  parameter int unsigned PWM_TOP = LFS_PWM_TOP
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  cmd_word_t             req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output duty_word_t            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LFS_ADDR_W-1:0] paddr,
  input  logic [LFS_DATA_W-1:0] pwdata,
  output logic [LFS_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [LFS_DUTY_W-1:0] TOP      = LFS_DUTY_W'(PWM_TOP);
  localparam logic [16:0]           TOP_WIDE = 17'(PWM_TOP);
  localparam int unsigned           PCT_UNIT = PWM_TOP / LFS_PERCENT;

  // Configuration registers.
  logic [7:0]            refresh_interval;
  logic [15:0]           fade_on_time;
  logic [15:0]           stay_on_time;
  logic [15:0]           fade_off_time;
  logic [LFS_DUTY_W-1:0] bright_amount;
  logic [LFS_DUTY_W-1:0] spot_amount;

  // Animation state.
  mode_t                 mode;
  phase_t                phase;
  logic [31:0]           tick_count;
  logic [LFS_DUTY_W-1:0] duty [LFS_NUM_CH];
  logic [1:0]            spot_index;
  logic [LFS_DUTY_W-1:0] fade_start;
  logic [6:0]            manual_percent;
  logic [15:0]           ping_limit;
  logic                  busy;

  mode_t                 mode_next;
  phase_t                phase_next;
  logic [31:0]           tick_next;
  logic [LFS_DUTY_W-1:0] duty_next [LFS_NUM_CH];
  logic [1:0]            spot_next;
  logic [LFS_DUTY_W-1:0] fade_start_next;
  logic [6:0]            manual_percent_next;
  logic [15:0]           ping_limit_next;
  logic                  busy_next;

  // Sequencer and held command word.
  seq_t                  seq;
  seq_t                  seq_next;
  cmd_word_t             cmd_q;
  logic                  due_refresh;
  logic                  rem_zero;
  logic [18:0]           quo_q;
  div_ctl_t              div_ctl;
  div_res_t              div_res;
  logic                  apply_fire;
  logic                  cfg_write;

  // Derived operands.
  logic [7:0]            refresh_eff;
  logic [15:0]           fade_on_eff;
  logic [31:0]           tick_inc;
  logic [16:0]           pct_product;
  logic [LFS_DUTY_W-1:0] target;
  logic                  fade_down;
  logic [LFS_DUTY_W-1:0] delta;
  logic [18:0]           bright_scaled;
  logic [18:0]           man_step;

  function automatic logic [LFS_DUTY_W-1:0] sub_sat(input logic [LFS_DUTY_W-1:0] a,
                                                   input logic [18:0] b);
    logic [18:0] a_wide;
    a_wide = 19'(a);
    return (a_wide > b) ? LFS_DUTY_W'(a_wide - b) : '0;
  endfunction

  function automatic logic [LFS_DUTY_W-1:0] add_sat(input logic [LFS_DUTY_W-1:0] a,
                                                   input logic [18:0] b);
    logic [19:0] sum;
    sum = 20'(a) + 20'(b);
    return (sum > 20'(PWM_TOP)) ? TOP : sum[LFS_DUTY_W-1:0];
  endfunction

  // True once ten times the counter has reached the limit; a counter of 8192 or
  // more always exceeds any 16-bit limit.
  function automatic logic reached(input logic [31:0] t, input logic [15:0] limit);
    logic [16:0] scaled;
    scaled = 17'(t[12:0]) * 17'(LFS_TIME_SCALE);
    return (t[31:13] != '0) || (scaled >= 17'(limit));
  endfunction

  assign refresh_eff   = (refresh_interval == '0) ? 8'd1 : refresh_interval;
  assign fade_on_eff   = (fade_on_time == '0) ? 16'd1 : fade_on_time;
  assign tick_inc      = tick_count + 32'd1;
  assign pct_product   = 17'(PCT_UNIT) * 17'(manual_percent);
  assign target        = (pct_product >= TOP_WIDE) ? '0
                                                   : LFS_DUTY_W'(TOP_WIDE - pct_product);
  assign fade_down     = fade_start > target;
  assign delta         = fade_down ? (fade_start - target) : (target - fade_start);
  assign bright_scaled = 19'(bright_amount) * 19'(LFS_TIME_SCALE);
  assign man_step      = (quo_q == '0) ? 19'd1 : quo_q;

  assign req_ready  = (seq == SQ_IDLE);
  assign apply_fire = (seq == SQ_APPLY) && (!rsp_valid || rsp_ready);
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_REFRESH:  prdata = 32'(refresh_interval);
      REG_FADE_ON:  prdata = 32'(fade_on_time);
      REG_STAY_ON:  prdata = 32'(stay_on_time);
      REG_FADE_OFF: prdata = 32'(fade_off_time);
      REG_BRIGHT:   prdata = 32'(bright_amount);
      REG_SPOT:     prdata = 32'(spot_amount);
      default:      prdata = '0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval <= 8'(LFS_RST_REFRESH);
      fade_on_time     <= 16'(LFS_RST_FADE_ON);
      stay_on_time     <= 16'(LFS_RST_STAY_ON);
      fade_off_time    <= 16'(LFS_RST_FADE_OFF);
      bright_amount    <= LFS_DUTY_W'(PWM_TOP / LFS_BRIGHT_DIV);
      spot_amount      <= LFS_DUTY_W'(PWM_TOP / LFS_SPOT_DIV);
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_REFRESH:  refresh_interval <= pwdata[7:0];
        REG_FADE_ON:  fade_on_time     <= pwdata[15:0];
        REG_STAY_ON:  stay_on_time     <= pwdata[15:0];
        REG_FADE_OFF: fade_off_time    <= pwdata[15:0];
        REG_BRIGHT:   bright_amount    <= pwdata[LFS_DUTY_W-1:0];
        REG_SPOT:     spot_amount      <= pwdata[LFS_DUTY_W-1:0];
        default:      ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // Sequencer next state and divider requests.
  always_comb begin
    seq_next         = seq;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = tick_inc;
    div_ctl.divisor  = 16'(refresh_eff);
    case (seq)
      SQ_IDLE: begin
        if (req_valid) begin
          if (req.command == CMD_TICK && mode != MODE_IDLE) begin
            seq_next = SQ_MOD_START;
          end else begin
            seq_next = SQ_APPLY;
          end
        end
      end
      SQ_MOD_START: begin
        div_ctl.start = 1'b1;
        seq_next      = SQ_MOD_WAIT;
      end
      SQ_MOD_WAIT: begin
        if (div_res.done) begin
          seq_next = SQ_QUO_START;
        end
      end
      SQ_QUO_START: begin
        div_ctl.start = 1'b1;
        case (mode)
          MODE_LIGHT: begin
            div_ctl.dividend = 32'(bright_scaled);
            div_ctl.divisor  = fade_on_eff;
          end
          MODE_MANUAL: begin
            div_ctl.dividend = 32'(delta);
            div_ctl.divisor  = 16'(LFS_MAN_STEPS);
          end
          default: begin
            div_ctl.dividend = tick_inc;
            div_ctl.divisor  = 16'(LFS_SPOT_TICKS);
          end
        endcase
        seq_next = SQ_QUO_WAIT;
      end
      SQ_QUO_WAIT: begin
        if (div_res.done) begin
          seq_next = SQ_APPLY;
        end
      end
      SQ_APPLY: begin
        if (apply_fire) begin
          seq_next = SQ_IDLE;
        end
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  lfs_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .res (div_res)
  );

  // Command word and divider results held for the update.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd_q <= req;
    end
    if (seq == SQ_MOD_WAIT && div_res.done) begin
      due_refresh <= (div_res.remainder == '0);
    end
    if (seq == SQ_QUO_WAIT && div_res.done) begin
      quo_q    <= div_res.quotient[18:0];
      rem_zero <= (div_res.remainder == '0);
    end
  end

  // Animation update for the held command.
  always_comb begin
    mode_next           = mode;
    phase_next          = phase;
    tick_next           = tick_count;
    duty_next           = duty;
    spot_next           = spot_index;
    fade_start_next     = fade_start;
    manual_percent_next = manual_percent;
    ping_limit_next     = ping_limit;
    busy_next           = busy;
    case (cmd_q.command)
      CMD_TICK: begin
        case (mode)
          MODE_LIGHT: begin
            tick_next = tick_inc;
            if (due_refresh) begin
              case (phase)
                PH_OFF: begin
                  tick_next    = '0;
                  phase_next   = PH_FADE_ON;
                  duty_next[0] = TOP;
                end
                PH_FADE_ON: begin
                  duty_next[0] = sub_sat(duty[0], quo_q);
                  if (reached(tick_inc, fade_on_time)) begin
                    phase_next = PH_STAY;
                    tick_next  = '0;
                  end
                end
                PH_STAY: begin
                  duty_next[0] = sub_sat(TOP, 19'(bright_amount));
                  if (reached(tick_inc, stay_on_time)) begin
                    phase_next = PH_FADE_OFF;
                    tick_next  = '0;
                  end
                end
                PH_FADE_OFF: begin
                  duty_next[0] = add_sat(duty[0], quo_q);
                  if (reached(tick_inc, fade_off_time)) begin
                    phase_next   = PH_DONE;
                    duty_next[0] = TOP;
                    tick_next    = '0;
                  end
                end
                PH_DONE: begin
                  tick_next = '0;
                  busy_next = 1'b0;
                end
                default: phase_next = PH_OFF;
              endcase
            end
          end
          MODE_MANUAL: begin
            tick_next = tick_inc;
            if (phase == PH_MAN_START) begin
              fade_start_next = duty[0];
              tick_next       = '0;
              phase_next      = PH_MAN_FADE;
            end else if (phase == PH_MAN_FADE && due_refresh) begin
              // Step toward the target and stop on it without overshoot.
              if (fade_down) begin
                if (sub_sat(duty[0], man_step) > target) begin
                  duty_next[0] = sub_sat(duty[0], man_step);
                end else begin
                  duty_next[0] = target;
                  phase_next   = PH_MAN_STOP;
                end
              end else begin
                if (add_sat(duty[0], man_step) < target) begin
                  duty_next[0] = add_sat(duty[0], man_step);
                end else begin
                  duty_next[0] = target;
                  phase_next   = PH_MAN_STOP;
                end
              end
            end
          end
          MODE_PING: begin
            tick_next = tick_inc;
            if (due_refresh) begin
              if (phase == PH_OFF) begin
                tick_next  = '0;
                phase_next = PH_SPOT;
              end else if (phase == PH_SPOT && rem_zero) begin
                // Move the dimmed spot on by one channel.
                duty_next[spot_index]         = TOP;
                spot_next                     = spot_index + 2'd1;
                duty_next[spot_index + 2'd1]  = sub_sat(TOP, 19'(spot_amount));
                if (reached(tick_inc, ping_limit)) begin
                  phase_next = PH_DONE;
                  tick_next  = '0;
                end
              end else if (phase == PH_DONE) begin
                busy_next = 1'b0;
                spot_next = '0;
                for (int i = 0; i < LFS_NUM_CH; i++) begin
                  duty_next[i] = TOP;
                end
              end
            end
          end
          default: ;
        endcase
      end
      CMD_LIGHT: begin
        busy_next  = 1'b1;
        mode_next  = MODE_LIGHT;
        phase_next = PH_OFF;
        tick_next  = '0;
      end
      CMD_STOP: begin
        busy_next = 1'b0;
        mode_next = MODE_IDLE;
      end
      CMD_MANUAL: begin
        busy_next           = 1'b1;
        mode_next           = MODE_MANUAL;
        phase_next          = PH_MAN_START;
        manual_percent_next = cmd_q.level_percent;
      end
      CMD_PING: begin
        busy_next       = 1'b1;
        ping_limit_next = cmd_q.ping_timeout;
        mode_next       = MODE_PING;
        phase_next      = PH_OFF;
        tick_next       = '0;
      end
      default: ;
    endcase
  end

  // State update and output word, taken together when the output can be loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      phase          <= PH_OFF;
      tick_count     <= '0;
      for (int i = 0; i < LFS_NUM_CH; i++) begin
        duty[i] <= TOP;
      end
      spot_index     <= '0;
      fade_start     <= '0;
      manual_percent <= '0;
      ping_limit     <= '0;
      busy           <= 1'b0;
      rsp_valid      <= 1'b0;
    end else if (apply_fire) begin
      mode           <= mode_next;
      phase          <= phase_next;
      tick_count     <= tick_next;
      duty           <= duty_next;
      spot_index     <= spot_next;
      fade_start     <= fade_start_next;
      manual_percent <= manual_percent_next;
      ping_limit     <= ping_limit_next;
      busy           <= busy_next;
      rsp_valid      <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      rsp.duty_ch0 <= duty_next[0];
      rsp.duty_ch1 <= duty_next[1];
      rsp.duty_ch2 <= duty_next[2];
      rsp.duty_ch3 <= duty_next[3];
      rsp.running  <= busy_next;
    end
  end

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (seq == SQ_MOD_WAIT || seq == SQ_QUO_WAIT))
    else $error("divider result arrived outside a wait state");

  // Channel values never leave the range up to the PWM top.
  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.duty_ch0 <= TOP && rsp.duty_ch1 <= TOP &&
                   rsp.duty_ch2 <= TOP && rsp.duty_ch3 <= TOP))
    else $error("duty value above PWM top");

  // An idle mode never reports a running animation.
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> !busy)
    else $error("running flag set while idle");

  // An update always leaves a result word on the output.
  a_apply_gives_word: assert property (@(posedge clk) disable iff (rst)
    apply_fire |=> rsp_valid)
    else $error("update without a result word");

  // A tick in an active mode goes through the divider before any update.
  a_tick_uses_div: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.command == CMD_TICK && mode != MODE_IDLE)
      |=> (seq == SQ_MOD_START))
    else $error("tick skipped the refresh check");

endmodule

@@ design/lfs_div.sv @@
// Iterative restoring divider, two quotient bits per cycle.
module lfs_div import lfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_ctl_t ctl,
  output div_res_t res
);

  localparam int unsigned CNT_W = $clog2(LFS_DIV_STEPS);

  logic                      busy;
  logic                      done;
  logic [CNT_W-1:0]          cnt;
  logic [LFS_DIVIDEND_W-1:0] quo;
  logic [LFS_DIVISOR_W-1:0]  rem;
  logic [LFS_DIVISOR_W-1:0]  dvs;

  logic [LFS_DIVISOR_W:0]    trial_a;
  logic [LFS_DIVISOR_W:0]    trial_b;
  logic [LFS_DIVISOR_W:0]    diff_a;
  logic [LFS_DIVISOR_W:0]    diff_b;
  logic                      ge_a;
  logic                      ge_b;
  logic [LFS_DIVIDEND_W-1:0] quo_next;
  logic [LFS_DIVISOR_W-1:0]  rem_next;

  // Two dependent compare-and-subtract steps on the partial remainder.
  always_comb begin
    trial_a  = {rem, quo[LFS_DIVIDEND_W-1]};
    ge_a     = trial_a >= {1'b0, dvs};
    diff_a   = ge_a ? (trial_a - {1'b0, dvs}) : trial_a;
    trial_b  = {diff_a[LFS_DIVISOR_W-1:0], quo[LFS_DIVIDEND_W-2]};
    ge_b     = trial_b >= {1'b0, dvs};
    diff_b   = ge_b ? (trial_b - {1'b0, dvs}) : trial_b;
    quo_next = {quo[LFS_DIVIDEND_W-3:0], ge_a, ge_b};
    rem_next = diff_b[LFS_DIVISOR_W-1:0];
  end

  // Control: load on start, then one radix-4 step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(LFS_DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      quo <= ctl.dividend;
      rem <= '0;
      dvs <= ctl.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

@@ tb/duty_checker.sv @@
// Checker of the LED fade sequencer: predicts every duty word and compares it with the block.
module duty_checker import lfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  cmd_word_t             req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  duty_word_t            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [LFS_ADDR_W-1:0] paddr,
  input  logic [LFS_DATA_W-1:0] pwdata,
  output int unsigned           mismatches,
  output int unsigned           words_pending
);

  localparam int unsigned TOP = LFS_PWM_TOP;

  // Our own copies of the registers.
  logic [7:0]  cfg_refresh;
  logic [15:0] cfg_fade_on;
  logic [15:0] cfg_stay_on;
  logic [15:0] cfg_fade_off;
  logic [14:0] cfg_bright;
  logic [14:0] cfg_spot;

  // Animation state as the block should hold it.
  mode_t       mode_now;
  phase_t      phase_now;
  logic [31:0] tick_cnt;
  int unsigned duty_now [LFS_NUM_CH];
  logic [1:0]  spot_pos;
  int unsigned fade_from;
  logic [6:0]  level_pct;
  logic [15:0] ping_lim;
  logic        busy_now;

  // Duty words still owed by the block, oldest first.
  duty_word_t expected_duty [$];

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  function automatic int unsigned sat_sub(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int unsigned sat_add(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > TOP) ? TOP : s;
  endfunction

  // The counter is scaled by ten without loss before it is compared with a duration.
  function automatic bit limit_hit(input int unsigned lim);
    longint unsigned scaled;
    scaled = tick_cnt;
    scaled = scaled * LFS_TIME_SCALE;
    return scaled >= lim;
  endfunction

  // A zero refresh interval behaves as one.
  function automatic bit update_due();
    int unsigned ri;
    ri = (cfg_refresh == 0) ? 1 : cfg_refresh;
    return (tick_cnt % ri) == 0;
  endfunction

  task automatic reset_model();
    cfg_refresh  = 8'(LFS_RST_REFRESH);
    cfg_fade_on  = 16'(LFS_RST_FADE_ON);
    cfg_stay_on  = 16'(LFS_RST_STAY_ON);
    cfg_fade_off = 16'(LFS_RST_FADE_OFF);
    cfg_bright   = 15'(TOP / LFS_BRIGHT_DIV);
    cfg_spot     = 15'(TOP / LFS_SPOT_DIV);
    mode_now     = MODE_IDLE;
    phase_now    = PH_OFF;
    tick_cnt     = '0;
    for (int i = 0; i < LFS_NUM_CH; i++) duty_now[i] = TOP;
    spot_pos     = '0;
    fade_from    = 0;
    level_pct    = '0;
    ping_lim     = '0;
    busy_now     = 1'b0;
  endtask

  task automatic write_register(input logic [LFS_ADDR_W-1:0] addr,
                                input logic [LFS_DATA_W-1:0] data);
    case (reg_idx_t'(addr[LFS_ADDR_W-1:2]))
      REG_REFRESH:  cfg_refresh  = data[7:0];
      REG_FADE_ON:  cfg_fade_on  = data[15:0];
      REG_STAY_ON:  cfg_stay_on  = data[15:0];
      REG_FADE_OFF: cfg_fade_off = data[15:0];
      REG_BRIGHT:   cfg_bright   = data[14:0];
      REG_SPOT:     cfg_spot     = data[14:0];
      default: ;
    endcase
  endtask

  // Light mode: fade channel 0 on, hold it, fade it off, then finish.
  task automatic light_update();
    int unsigned value, stride, fot;
    tick_cnt = tick_cnt + 1;
    if (update_due()) begin
      value  = duty_now[0];
      fot    = (cfg_fade_on == 0) ? 1 : cfg_fade_on;
      stride = int'(cfg_bright) * LFS_TIME_SCALE / fot;
      case (phase_now)
        PH_OFF: begin
          tick_cnt  = '0;
          phase_now = PH_FADE_ON;
          value     = TOP;
        end
        PH_FADE_ON: begin
          value = sat_sub(value, stride);
          if (limit_hit(cfg_fade_on)) begin
            phase_now = PH_STAY;
            tick_cnt  = '0;
          end
        end
        PH_STAY: begin
          value = sat_sub(TOP, cfg_bright);
          if (limit_hit(cfg_stay_on)) begin
            phase_now = PH_FADE_OFF;
            tick_cnt  = '0;
          end
        end
        PH_FADE_OFF: begin
          value = sat_add(value, stride);
          if (limit_hit(cfg_fade_off)) begin
            phase_now = PH_DONE;
            value     = TOP;
            tick_cnt  = '0;
          end
        end
        PH_DONE: begin
          tick_cnt = '0;
          busy_now = 1'b0;
        end
        default: phase_now = PH_OFF;
      endcase
      duty_now[0] = value;
    end
  endtask

  // Manual mode: step channel 0 from where it stood toward the percent level.
  task automatic manual_update();
    int unsigned target, value, delta, stride;
    bit          going_down;
    target   = sat_sub(TOP, TOP / LFS_PERCENT * level_pct);
    value    = duty_now[0];
    tick_cnt = tick_cnt + 1;
    if (phase_now == PH_MAN_START) begin
      fade_from = duty_now[0];
      tick_cnt  = '0;
      phase_now = PH_MAN_FADE;
    end else if (phase_now == PH_MAN_FADE && update_due()) begin
      going_down = fade_from > target;
      delta      = going_down ? fade_from - target : target - fade_from;
      stride     = delta / LFS_MAN_STEPS;
      if (stride == 0) stride = 1;
      if (going_down) begin
        value = sat_sub(value, stride);
        if (value > target) begin
          duty_now[0] = value;
        end else begin
          duty_now[0] = target;
          phase_now   = PH_MAN_STOP;
        end
      end else begin
        value = sat_add(value, stride);
        if (value < target) begin
          duty_now[0] = value;
        end else begin
          duty_now[0] = target;
          phase_now   = PH_MAN_STOP;
        end
      end
    end
  endtask

  // Ping mode: move the dimmed spot on every twentieth count until the timeout.
  task automatic ping_update();
    tick_cnt = tick_cnt + 1;
    if (update_due()) begin
      if (phase_now == PH_OFF) begin
        tick_cnt  = '0;
        phase_now = PH_SPOT;
      end else if (phase_now == PH_SPOT && (tick_cnt % LFS_SPOT_TICKS) == 0) begin
        duty_now[spot_pos] = TOP;
        spot_pos           = spot_pos + 2'd1;
        duty_now[spot_pos] = sat_sub(TOP, cfg_spot);
        if (limit_hit(ping_lim)) begin
          phase_now = PH_DONE;
          tick_cnt  = '0;
        end
      end else if (phase_now == PH_DONE) begin
        busy_now = 1'b0;
        spot_pos = '0;
        for (int i = 0; i < LFS_NUM_CH; i++) duty_now[i] = TOP;
      end
    end
  endtask

  // Works out the duty word that one command word should produce.
  task automatic predict_duty(input cmd_word_t w, output duty_word_t o);
    case (w.command)
      CMD_TICK: begin
        if (mode_now == MODE_LIGHT) light_update();
        else if (mode_now == MODE_MANUAL) manual_update();
        else if (mode_now == MODE_PING) ping_update();
      end
      CMD_LIGHT: begin
        busy_now  = 1'b1;
        mode_now  = MODE_LIGHT;
        phase_now = PH_OFF;
        tick_cnt  = '0;
      end
      CMD_STOP: begin
        busy_now = 1'b0;
        mode_now = MODE_IDLE;
      end
      CMD_MANUAL: begin
        busy_now  = 1'b1;
        mode_now  = MODE_MANUAL;
        phase_now = PH_MAN_START;
        level_pct = w.level_percent;
      end
      CMD_PING: begin
        busy_now  = 1'b1;
        ping_lim  = w.ping_timeout;
        mode_now  = MODE_PING;
        phase_now = PH_OFF;
        tick_cnt  = '0;
      end
      default: ;
    endcase
    o.duty_ch0 = duty_now[0][LFS_DUTY_W-1:0];
    o.duty_ch1 = duty_now[1][LFS_DUTY_W-1:0];
    o.duty_ch2 = duty_now[2][LFS_DUTY_W-1:0];
    o.duty_ch3 = duty_now[3][LFS_DUTY_W-1:0];
    o.running  = busy_now;
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  // Register writes first, then the returned word, then the newly accepted word.
  always @(posedge clk) begin : watch_channels
    duty_word_t want;
    if (rst) begin
      reset_model();
      expected_duty.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      if (rsp_valid && rsp_ready) begin
        if (expected_duty.size() == 0) begin
          $display("%0t: unexpected duty word, expected none, actual %h", $time, rsp);
          mismatches = mismatches + 1;
        end else begin
          want = expected_duty.pop_front();
          check_field("duty_ch0", 16'(want.duty_ch0), 16'(rsp.duty_ch0));
          check_field("duty_ch1", 16'(want.duty_ch1), 16'(rsp.duty_ch1));
          check_field("duty_ch2", 16'(want.duty_ch2), 16'(rsp.duty_ch2));
          check_field("duty_ch3", 16'(want.duty_ch3), 16'(rsp.duty_ch3));
          check_field("running", 16'(want.running), 16'(rsp.running));
        end
      end
      if (req_valid && req_ready) begin
        predict_duty(req, want);
        expected_duty.push_back(want);
      end
    end
    words_pending = expected_duty.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the LED fade sequencer testbench: clock, reset, stimulus, register writes and verdict.
module testbench;
  import lfs_pkg::*;

  localparam int ITEM_TARGET   = 1200;
  localparam int PHASES        = 8;
  localparam int MAX_RUN       = 300;
  localparam int CMD_CODES     = 8;
  // Covers a tick through the divider, the longest sender gap and receiver stall, plus margin.
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  cmd_word_t             req       = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b1;
  duty_word_t            rsp;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [LFS_ADDR_W-1:0] paddr     = '0;
  logic [LFS_DATA_W-1:0] pwdata    = '0;
  logic [LFS_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned words_pending;

  // Stimulus bookkeeping and the register values in force.
  int sent        = 0;
  bit no_idle     = 1'b0;
  bit sender_calm = 1'b0;
  int cfg_refresh  = LFS_RST_REFRESH;
  int cfg_fade_on  = LFS_RST_FADE_ON;
  int cfg_stay_on  = LFS_RST_STAY_ON;
  int cfg_fade_off = LFS_RST_FADE_OFF;

  int stall_left   = 0;
  int calm_left    = 0;
  int quiet_cycles = 0;

  led_fade_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  duty_checker duty_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  // Clock of period 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stalls come in bursts, with calm stretches between.
  always @(negedge clk) begin
    if (rst || no_idle) begin
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm_left > 0) begin
      rsp_ready <= 1'b1;
      calm_left = calm_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          rsp_ready  <= 1'b0;
          stall_left = $urandom_range(0, 5);
        end
        4: begin
          rsp_ready <= 1'b1;
          calm_left = $urandom_range(50, 300);
        end
        default: rsp_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: ends the run when nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_word_t make_word(input logic [2:0] code, input logic [6:0] level,
                                          input logic [15:0] timeout);
    cmd_word_t w;
    w.command       = code;
    w.level_percent = level;
    w.ping_timeout  = timeout;
    return w;
  endfunction

  // Ticks carry random bits in the fields that they leave unused.
  function automatic cmd_word_t tick_word();
    return make_word(CMD_TICK, 7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)));
  endfunction

  function automatic cmd_word_t any_word();
    return make_word(3'($urandom_range(0, CMD_CODES - 1)), 7'($urandom_range(0, 127)),
                     16'($urandom_range(0, 65535)));
  endfunction

  function automatic int random_span();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) return $urandom_range(1, 300);
    else if (pick == 8) return 0;
    else return $urandom_range(0, 65535);
  endfunction

  function automatic int random_depth();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1000) : $urandom_range(0, 32767);
  endfunction

  // Presents one command word at a falling edge and holds it until it is taken.
  task automatic send_word(input cmd_word_t w);
    @(negedge clk);
    if (!no_idle && !sender_calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent = sent + 1;
  endtask

  // Stops sending and waits until every duty word owed has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input reg_idx_t idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int r, input int fon, input int stay, input int foff,
                            input int bright, input int spot);
    write_reg(REG_REFRESH, r);
    write_reg(REG_FADE_ON, fon);
    write_reg(REG_STAY_ON, stay);
    write_reg(REG_FADE_OFF, foff);
    write_reg(REG_BRIGHT, bright);
    write_reg(REG_SPOT, spot);
    cfg_refresh  = r;
    cfg_fade_on  = fon;
    cfg_stay_on  = stay;
    cfg_fade_off = foff;
  endtask

  // One scenario: a start command and up to MAX_RUN ticks, with stray words, or a short run of random words.
  task automatic run_scenario();
    int        kind, n, ri, timeout;
    logic [6:0] level;
    ri          = (cfg_refresh == 0) ? 1 : cfg_refresh;
    sender_calm = ($urandom_range(0, 3) == 0);
    kind        = $urandom_range(0, 9);
    n           = 0;
    if (kind < 3) begin
      send_word(make_word(CMD_LIGHT, 7'($urandom_range(0, 127)),
                          16'($urandom_range(0, 65535))));
      n = (cfg_fade_on + cfg_stay_on + cfg_fade_off) / 10 + 6 * ri + $urandom_range(0, 10);
    end else if (kind < 6) begin
      level = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
      send_word(make_word(CMD_MANUAL, level, 16'($urandom_range(0, 65535))));
      n = ri * 60 + $urandom_range(0, 60);
    end else if (kind < 9) begin
      timeout = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
      send_word(make_word(CMD_PING, 7'($urandom_range(0, 127)), 16'(timeout)));
      n = (ri <= 4) ? timeout / 10 + 80 : $urandom_range(20, MAX_RUN);
    end else begin
      repeat ($urandom_range(1, 8)) send_word(any_word());
    end
    if (n > MAX_RUN) n = MAX_RUN;
    repeat (n) send_word(($urandom_range(0, 29) == 0) ? any_word() : tick_word());
    // Now and then let the block run dry before the next animation.
    if ($urandom_range(0, 9) == 0) wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: idle ticks, unused codes, stop while idle and each start command.
    send_word(make_word(CMD_TICK, 7'h7F, 16'hFFFF));
    send_word(make_word(CMD_TICK, 7'h00, 16'h0000));
    for (int c = int'(CMD_PING) + 1; c < CMD_CODES; c++) begin
      send_word(make_word(3'(c), 7'h55, 16'hAAAA));
    end
    send_word(make_word(CMD_STOP, 7'h2A, 16'h5555));
    send_word(make_word(CMD_MANUAL, 7'd127, 16'h0000));
    repeat (3) send_word(tick_word());
    send_word(make_word(CMD_MANUAL, 7'd100, 16'h0000));
    send_word(tick_word());
    send_word(make_word(CMD_MANUAL, 7'd0, 16'h0000));
    send_word(tick_word());
    send_word(make_word(CMD_PING, 7'd0, 16'h0000));
    repeat (3) send_word(tick_word());
    send_word(make_word(CMD_PING, 7'd0, 16'hFFFF));
    send_word(tick_word());
    send_word(make_word(CMD_LIGHT, 7'd0, 16'h0000));
    repeat (2) send_word(tick_word());
    send_word(make_word(CMD_STOP, 7'd0, 16'h0000));
    send_word(tick_word());

    // Random phases, each under its own register setting; the last one without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_for_results();
        if (ph == 1) set_config(0, 0, 0, 0, 0, 0);
        else if (ph == 2) set_config(255, 65535, 65535, 65535, 32767, 32767);
        else set_config(($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) :
                          ($urandom_range(0, 2) < 2) ? $urandom_range(0, 8) :
                          $urandom_range(0, 255),
                        random_span(), random_span(), random_span(),
                        random_depth(), random_depth());
      end
      no_idle = (ph == PHASES - 1);
      while (sent < (ph + 1) * ITEM_TARGET / PHASES) run_scenario();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ led_fade_sequencer.f @@
design/lfs_pkg.sv
design/lfs_div.sv
design/led_fade_sequencer.sv
tb/duty_checker.sv
tb/testbench.sv
